/* hdl/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and codes shared by the length-prefixed packet ring.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int CFG_W      = 13;
  localparam int CNT_W      = 12;
  localparam int SIZE_RESET = 4096;
  localparam int MIN_SIZE   = 4;

  // func field codes
  localparam logic [3:0] F_CLR   = 4'd0;
  localparam logic [3:0] F_START = 4'd1;
  localparam logic [3:0] F_PUT   = 4'd2;
  localparam logic [3:0] F_END   = 4'd3;
  localparam logic [3:0] F_HDR   = 4'd4;
  localparam logic [3:0] F_RDB   = 4'd5;
  localparam logic [3:0] F_SKIP  = 4'd6;
  localparam logic [3:0] F_SAVE  = 4'd7;
  localparam logic [3:0] F_REST  = 4'd8;

  typedef enum logic [3:0] {
    OP_CLR, OP_START, OP_PUT, OP_END, OP_HDR,
    OP_RDB, OP_SKIP, OP_SAVE, OP_REST, OP_NOP
  } op_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [7:0]  data_byte;
    logic [15:0] skip_count;
    logic        restore;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [11:0] length_out;
    logic [11:0] moved_count;
    logic [11:0] packets_held;
    logic [31:0] dropped_total;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;
    logic [15:0] skip_count;
  } cmd_t;

endpackage

/* hdl/length_prefixed_packet_ring.sv */
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring
// Ring store of packets behind two-byte length headers, oldest dropped first.
// ----------------------------------------------------------------------------
// Items pass a two-beat input queue into a sequencer that owns the single
// byte store (one write, one registered read per cycle). Status-only items
// go straight to ST_OUT; byte read via ST_RDD, skip via ST_SKP, end write via
// ST_HW2 (none if oversized), read header via ST_HI/LO/LEN (none with no
// packet waiting), put byte via ST_CHK and ST_WR, with ST_HI/LO/LEN/ADV between
// when the oldest packet must first be discarded (two header bytes fetched
// through the store's read port); start write makes two such byte writes. A
// result sits in a one-beat output register; the next item starts once taken.
module length_prefixed_packet_ring import lpr_pkg::*; #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  in_item_t         in_data,
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  lpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  lpr_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_size  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

/* hdl/lpr_ram.sv */
// ----------------------------------------------------------------------------
// lpr_ram
// Generic RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lpr_front.sv */
// ----------------------------------------------------------------------------
// lpr_front
// Input side: decodes each beat into an operation and holds it in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lpr_front import lpr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       do_push, do_pop;

  always_comb begin
    dec.data_byte  = in_data.data_byte;
    dec.skip_count = in_data.skip_count;
    unique case (in_data.func)
      F_CLR:   dec.op = OP_CLR;
      F_START: dec.op = OP_START;
      F_PUT:   dec.op = OP_PUT;
      F_END:   dec.op = OP_END;
      F_HDR:   dec.op = OP_HDR;
      F_RDB:   dec.op = OP_RDB;
      F_SKIP:  dec.op = OP_SKIP;
      F_SAVE:  dec.op = OP_SAVE;
      F_REST:  dec.op = in_data.restore ? OP_REST : OP_NOP;
      default: dec.op = OP_NOP;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

/* hdl/lpr_back.sv */
// ----------------------------------------------------------------------------
// lpr_back
// Execution side: sequencer over the byte store, ring pointers and counters,
// with a one-entry result register.
// ----------------------------------------------------------------------------
module lpr_back import lpr_pkg::*; #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  input  logic             cfg_wr,
  input  logic [CFG_W-1:0] cfg_size,
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_data
);

  localparam int PW  = $clog2(STORE_DEPTH);
  localparam int SZW = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;
  localparam logic [SZW-1:0] DEPTH_S = SZW'(STORE_DEPTH);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_CHK  = 11'b00000000010,
    ST_HI   = 11'b00000000100,
    ST_LO   = 11'b00000001000,
    ST_LEN  = 11'b00000010000,
    ST_ADV  = 11'b00000100000,
    ST_WR   = 11'b00001000000,
    ST_HW2  = 11'b00010000000,
    ST_RDD  = 11'b00100000000,
    ST_SKP  = 11'b01000000000,
    ST_OUT  = 11'b10000000000
  } state_t;

  state_t          st_r, st_nxt;
  op_t             op_r, op_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            sec_r, sec_nxt;
  logic            drop_mode_r, drop_mode_nxt;
  logic [7:0]      hi_r, hi_nxt;
  logic [SZW-1:0]  len_r, len_nxt;
  logic [SZW-1:0]  mv_r, mv_nxt;
  logic [SZW-1:0]  lo_r, lo_nxt;      // length_out
  logic [7:0]      rd_r, rd_nxt;

  logic [SZW-1:0]  size_r, size_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt, wptr_r, wptr_nxt, hs_r, hs_nxt;
  logic [PW-1:0]   srp_r, srp_nxt;
  logic [CNT_W-1:0] pc_r, pc_nxt, spc_r, spc_nxt;
  logic [SZW-1:0]  wl_r, wl_nxt, rr_r, rr_nxt;
  logic [31:0]     drop_r, drop_nxt;

  out_item_t       out_r, out_nxt;
  logic            ovld_r, ovld_nxt;

  logic            we;
  logic [PW-1:0]   waddr, raddr;
  logic [7:0]      wdata, rdata;

  logic [SZW-1:0]  clamp;
  logic [15:0]     hdr16;
  logic [SZW:0]    sum;

  function automatic logic [PW-1:0] nxt_ptr(input logic [PW-1:0] p,
                                            input logic [SZW-1:0] s);
    logic [SZW-1:0] t;
    t = SZW'(p) + SZW'(1);
    return (t >= s) ? '0 : t[PW-1:0];
  endfunction

  lpr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (cfg_size < CFG_W'(MIN_SIZE)) begin
      clamp = SZW'(MIN_SIZE);
    end else if (SZW'(cfg_size) > DEPTH_S) begin
      clamp = DEPTH_S;
    end else begin
      clamp = SZW'(cfg_size);
    end
  end

  assign cmd_ready = (st_r == ST_IDLE) && !ovld_r;
  assign empty     = !ovld_r;
  assign out_data  = out_r;
  assign hdr16     = {hi_r, rdata};

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; byte_nxt = byte_r; sec_nxt = sec_r;
    drop_mode_nxt = drop_mode_r; hi_nxt = hi_r; len_nxt = len_r; mv_nxt = mv_r;
    lo_nxt = lo_r; rd_nxt = rd_r;
    size_nxt = size_r; rptr_nxt = rptr_r; wptr_nxt = wptr_r; hs_nxt = hs_r;
    srp_nxt = srp_r; pc_nxt = pc_r; spc_nxt = spc_r; wl_nxt = wl_r; rr_nxt = rr_r;
    drop_nxt = drop_r; out_nxt = out_r;
    ovld_nxt = ovld_r && !pop;
    we = 1'b0; waddr = wptr_r; wdata = byte_r; raddr = rptr_r;
    sum = '0;

    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid && !ovld_r) begin
          op_nxt = cmd.op;
          lo_nxt = '0; mv_nxt = '0; rd_nxt = '0; sec_nxt = 1'b0;
          st_nxt = ST_OUT;
          unique case (cmd.op)
            OP_CLR: begin
              rptr_nxt = '0; wptr_nxt = '0; hs_nxt = '0; pc_nxt = '0;
              wl_nxt = '0; rr_nxt = '0; drop_nxt = '0; srp_nxt = '0; spc_nxt = '0;
            end
            OP_START: begin
              hs_nxt = wptr_r; byte_nxt = 8'h00; st_nxt = ST_CHK;
            end
            OP_PUT: begin
              byte_nxt = cmd.data_byte; st_nxt = ST_CHK;
            end
            OP_END: begin
              if (wl_r >= size_r - SZW'(2)) begin
                drop_nxt = drop_r + 32'(pc_r) + 32'd1;
                pc_nxt = '0; rptr_nxt = '0; wptr_nxt = '0;
              end else begin
                we = 1'b1; waddr = hs_r; wdata = 8'((wl_r >> 8) & SZW'(8'hff));
                st_nxt = ST_HW2;
              end
            end
            OP_HDR: begin
              if (pc_r != '0) begin
                drop_mode_nxt = 1'b0; st_nxt = ST_HI;
              end
            end
            OP_RDB: begin
              if (rr_r != '0) begin
                rptr_nxt = nxt_ptr(rptr_r, size_r); st_nxt = ST_RDD;
              end
            end
            OP_SKIP: begin
              if (rr_r != '0) begin
                mv_nxt = (SZW'(cmd.skip_count) > rr_r || (cmd.skip_count >> SZW) != '0)
                         ? rr_r : SZW'(cmd.skip_count);
                st_nxt = ST_SKP;
              end
            end
            OP_SAVE: begin
              srp_nxt = rptr_r; spc_nxt = pc_r;
            end
            OP_REST: begin
              rptr_nxt = srp_r; pc_nxt = spc_r;
            end
            default: ;
          endcase
        end
      end
      ST_CHK: begin
        if (pc_r != '0 && wptr_r == rptr_r) begin
          drop_mode_nxt = 1'b1; st_nxt = ST_HI;
        end else begin
          st_nxt = ST_WR;
        end
      end
      ST_HI: begin
        rptr_nxt = nxt_ptr(rptr_r, size_r); st_nxt = ST_LO;
      end
      ST_LO: begin
        hi_nxt = rdata; rptr_nxt = nxt_ptr(rptr_r, size_r); st_nxt = ST_LEN;
      end
      ST_LEN: begin
        // header capped at size-3
        len_nxt = (17'(hdr16) > 17'(size_r - SZW'(3))) ? size_r - SZW'(3)
                                                       : SZW'(hdr16);
        if (drop_mode_r) begin
          st_nxt = ST_ADV;
        end else begin
          rr_nxt = len_nxt; lo_nxt = len_nxt;
          if (len_nxt == '0 && pc_r != '0) pc_nxt = pc_r - CNT_W'(1);
          st_nxt = ST_OUT;
        end
      end
      ST_ADV: begin
        sum = (SZW+1)'(rptr_r) + (SZW+1)'(len_r);
        rptr_nxt = (sum >= (SZW+1)'(size_r)) ? PW'(sum - (SZW+1)'(size_r)) : PW'(sum);
        if (pc_r != '0) pc_nxt = pc_r - CNT_W'(1);
        drop_nxt = drop_r + 32'd1;
        st_nxt = ST_WR;
      end
      ST_WR: begin
        we = 1'b1;
        wptr_nxt = nxt_ptr(wptr_r, size_r);
        if (op_r == OP_START && !sec_r) begin
          sec_nxt = 1'b1; st_nxt = ST_CHK;
        end else begin
          if (op_r == OP_START) begin
            wl_nxt = '0;
          end else if (wl_r < size_r) begin
            wl_nxt = wl_r + SZW'(1);
          end
          st_nxt = ST_OUT;
        end
      end
      ST_HW2: begin
        we = 1'b1; waddr = nxt_ptr(hs_r, size_r); wdata = wl_r[7:0];
        if (pc_r != {CNT_W{1'b1}}) pc_nxt = pc_r + CNT_W'(1);
        st_nxt = ST_OUT;
      end
      ST_RDD: begin
        rd_nxt = rdata; mv_nxt = SZW'(1); rr_nxt = rr_r - SZW'(1);
        if (rr_r == SZW'(1) && pc_r != '0) pc_nxt = pc_r - CNT_W'(1);
        st_nxt = ST_OUT;
      end
      ST_SKP: begin
        sum = (SZW+1)'(rptr_r) + (SZW+1)'(mv_r);
        rptr_nxt = (sum >= (SZW+1)'(size_r)) ? PW'(sum - (SZW+1)'(size_r)) : PW'(sum);
        rr_nxt = rr_r - mv_r;
        if (rr_r == mv_r && pc_r != '0) pc_nxt = pc_r - CNT_W'(1);
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_nxt.read_data     = rd_r;
        out_nxt.length_out    = lo_r[CNT_W-1:0];
        out_nxt.moved_count   = mv_r[CNT_W-1:0];
        out_nxt.packets_held  = pc_r;
        out_nxt.dropped_total = drop_r;
        ovld_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase

    if (cfg_wr) begin
      size_nxt = clamp;
      rptr_nxt = '0; wptr_nxt = '0; hs_nxt = '0; pc_nxt = '0;
      wl_nxt = '0; rr_nxt = '0; drop_nxt = '0; srp_nxt = '0; spc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ovld_r <= 1'b0;
      size_r <= (SZW'(SIZE_RESET) > DEPTH_S) ? DEPTH_S : SZW'(SIZE_RESET);
      rptr_r <= '0; wptr_r <= '0; hs_r <= '0; pc_r <= '0;
      wl_r <= '0; rr_r <= '0; drop_r <= '0; srp_r <= '0; spc_r <= '0;
    end else begin
      st_r <= st_nxt; ovld_r <= ovld_nxt; size_r <= size_nxt;
      rptr_r <= rptr_nxt; wptr_r <= wptr_nxt; hs_r <= hs_nxt; pc_r <= pc_nxt;
      wl_r <= wl_nxt; rr_r <= rr_nxt; drop_r <= drop_nxt;
      srp_r <= srp_nxt; spc_r <= spc_nxt;
    end
    op_r <= op_nxt; byte_r <= byte_nxt; sec_r <= sec_nxt;
    drop_mode_r <= drop_mode_nxt; hi_r <= hi_nxt; len_r <= len_nxt;
    mv_r <= mv_nxt; lo_r <= lo_nxt; rd_r <= rd_nxt; out_r <= out_nxt;
  end

endmodule
